// ----- src/divider_64bit_signed_unsigned_macros.svh -----
// Assertion macros for the 64-bit signed/unsigned divider.
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_MACROS_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVSU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("divider check failed");

// The consequent must hold in the cycle after the antecedent.
`define DVSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("divider check failed");

`endif

// ----- src/dvsu_pkg.sv -----
// Shared types and constants for the 64-bit signed/unsigned divider.
`default_nettype none
package dvsu_pkg;

  localparam int DW    = 64;
  localparam int STEPS = DW;
  localparam int CW    = $clog2(STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_N,
    ST_NEG_D,
    ST_DIVIDE,
    ST_FIX_Q,
    ST_FIX_R,
    ST_DONE
  } dvsu_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_NEG_N,
    OP_NEG_D,
    OP_STEP,
    OP_NEG_Q,
    OP_NEG_R
  } dvsu_op_t;

endpackage
`default_nettype wire

// ----- src/dvsu_sub.sv -----
// Shared subtractor: one width-plus-one subtraction with borrow out.
`default_nettype none
module dvsu_sub
  import dvsu_pkg::*;
(
  input  logic [DW:0]   a,
  input  logic [DW:0]   b,
  output logic [DW-1:0] diff,
  output logic          borrow
);

  logic [DW+1:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[DW-1:0];
  assign borrow = full[DW+1];

endmodule
`default_nettype wire

// ----- src/dvsu_dp.sv -----
// Divider datapath: operand, remainder and quotient registers around the shared subtractor.
`default_nettype none
module dvsu_dp
  import dvsu_pkg::*;
(
  input  logic          clk,
  input  dvsu_op_t      op,
  input  logic          command,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder,
  output logic          divide_by_zero
);

  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dvs;
  logic          nneg;
  logic          dneg;
  logic          dbz;

  logic [DW:0]   sub_a;
  logic [DW:0]   sub_b;
  logic [DW-1:0] diff;
  logic          borrow;
  logic [DW:0]   trial;
  logic          dvs_zero;

  assign trial    = {rem, quo[DW-1]};
  assign dvs_zero = (divisor == '0);

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (op)
      OP_NEG_N: sub_b = {1'b0, quo};
      OP_NEG_D: sub_b = {1'b0, dvs};
      OP_STEP: begin
        sub_a = trial;
        sub_b = {1'b0, dvs};
      end
      OP_NEG_Q: sub_b = {1'b0, quo};
      OP_NEG_R: sub_b = {1'b0, rem};
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  dvsu_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (diff),
    .borrow (borrow)
  );

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        nneg <= command & dividend[DW-1];
        dneg <= command & divisor[DW-1];
        dvs  <= divisor;
        dbz  <= dvs_zero;
        // A zero divisor finishes here: all ones and the dividend as remainder.
        rem  <= dvs_zero ? dividend : '0;
        quo  <= dvs_zero ? '1 : dividend;
      end
      OP_NEG_N: begin
        if (nneg) begin
          quo <= diff;
        end
      end
      OP_NEG_D: begin
        if (dneg) begin
          dvs <= diff;
        end
      end
      OP_STEP: begin
        // The dividend shifts out of quo while quotient bits shift in.
        if (borrow) begin
          rem <= trial[DW-1:0];
          quo <= {quo[DW-2:0], 1'b0};
        end else begin
          rem <= diff;
          quo <= {quo[DW-2:0], 1'b1};
        end
      end
      OP_NEG_Q: begin
        if (nneg ^ dneg) begin
          quo <= diff;
        end
      end
      OP_NEG_R: begin
        if (nneg) begin
          rem <= diff;
        end
      end
      default: begin
      end
    endcase
  end

  assign quotient       = quo;
  assign remainder      = rem;
  assign divide_by_zero = dbz;

endmodule
`default_nettype wire

// ----- src/dvsu_ctrl.sv -----
// Divider sequencer: state machine and step counter that drive the datapath.
`default_nettype none
module dvsu_ctrl
  import dvsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     dbz,
  output dvsu_op_t op,
  output logic     busy,
  output logic     done
);

  localparam logic [CW-1:0] CNT_LAST = CW'(STEPS - 1);

  dvsu_state_t   state;
  dvsu_state_t   state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_NEG_N;
        end
      end
      ST_NEG_N: state_next = dbz ? ST_DONE : ST_NEG_D;
      ST_NEG_D: begin
        state_next = ST_DIVIDE;
        cnt_next   = '0;
      end
      ST_DIVIDE: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = ST_FIX_Q;
        end
      end
      ST_FIX_Q: state_next = ST_FIX_R;
      ST_FIX_R: state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op   = OP_NONE;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        op   = start ? OP_LOAD : OP_NONE;
      end
      // A zero divisor result is already in place and must not be touched.
      ST_NEG_N:  op = dbz ? OP_NONE : OP_NEG_N;
      ST_NEG_D:  op = OP_NEG_D;
      ST_DIVIDE: op = OP_STEP;
      ST_FIX_Q:  op = OP_NEG_Q;
      ST_FIX_R:  op = OP_NEG_R;
      ST_DONE:   done = 1'b1;
      default: begin
        op   = OP_NONE;
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/divider_64bit_signed_unsigned.sv -----
// Top level of the 64-bit signed/unsigned restoring divider.
//
//   Port group   Direction  Handshake     Contents
//   operands     in         start / busy  command, dividend, divisor
//   result       out        done strobe   quotient, remainder, divide_by_zero
//
// A transfer in takes place when start is high and busy is low. Busy then stays high through
// a sign fix state for each operand, 64 subtract steps through the shared subtractor, the
// quotient and remainder sign fix states and the done cycle, in which the result is shown.
// A zero divisor goes from the dividend sign fix state straight to done. The receiver cannot
// stall a result; the next transfer can be taken in the cycle after done.
// Reset (synchronous) returns the sequencer to idle.
`default_nettype none
`include "divider_64bit_signed_unsigned_macros.svh"
module divider_64bit_signed_unsigned
  import dvsu_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          command,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder,
  output logic          divide_by_zero
);

  dvsu_op_t op;

  dvsu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .dbz   (divide_by_zero),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  dvsu_dp u_dp (
    .clk            (clk),
    .op             (op),
    .command        (command),
    .dividend       (dividend),
    .divisor        (divisor),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  `DVSU_ASSERT_SAME(a_done_while_busy, clk, rst, done, busy)
  `DVSU_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy && !done)
  `DVSU_ASSERT_NEXT(a_done_returns_idle, clk, rst, done, !busy && !done)
  `DVSU_ASSERT_SAME(a_zero_div_ones, clk, rst, done && divide_by_zero, quotient == '1)

endmodule
`default_nettype wire
